// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/igpl_pkg.sv =====
// ---------------------------------------------------------------------------
// Isometric grid point-light package
// Widths, codes, transaction types and divider constants shared by the block.
// ---------------------------------------------------------------------------
package igpl_pkg;

    // Default sizes of the light table and the grid.
    localparam int unsigned MAX_LIGHTS_DEF = 16;
    localparam int unsigned GRID_DIM_DEF   = 1024;

    // Field widths.
    localparam int unsigned POS_W   = 24;
    localparam int unsigned CELL_W  = 10;
    localparam int unsigned INT_W   = 16;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 24;

    // Tile coordinate width: a 10-bit column plus half a 10-bit row, signed.
    localparam int unsigned TC_W  = 12;
    // Rounded per-axis magnitude and squared distance widths.
    localparam int unsigned MAG_W = 24;
    localparam int unsigned SQ_W  = 48;
    localparam logic [SQ_W-1:0] SQ_SAT = '1;

    // Request codes.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_INV = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

    // Reciprocal: q = (NUM + den/2) / den with den = 6553600 + S.
    localparam int unsigned Q_W   = 17;
    localparam int unsigned DEN_W = SQ_W + 1;
    localparam int unsigned REM_W = DEN_W + Q_W;
    localparam logic [REM_W-1:0] DIV_NUM = 66'd429496729600;
    localparam logic [DEN_W-1:0] DEN_OFS = 49'd6553600;

    // Input transaction.
    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [POS_W-1:0] light_x;
        logic signed [POS_W-1:0] light_y;
        logic [CELL_W-1:0]       cell_col;
        logic [CELL_W-1:0]       cell_row;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic [INT_W-1:0] intensity;
        logic             status;
    } t_out_item;

    // Query token handed from cell to cell.
    typedef struct packed {
        logic                   vld;
        logic signed [TC_W-1:0] tx;
        logic signed [TC_W-1:0] ty;
        logic [SQ_W-1:0]        best;
    } t_tok;

endpackage

// ===== hw/rtl/iso_grid_point_light_intensity_core.sv =====
// ---------------------------------------------------------------------------
// Isometric grid point-light intensity core
// Light table as a chain of cells; a grid query walks the chain collecting
// the smallest squared distance, then a divider turns it into intensity.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  in        input      i_in_valid/o_in_stall    t_in_item  (request)
//  out       output     o_out_valid/i_out_stall  t_out_item (result)
//  cfg       input      i_cfg_valid/o_cfg_ready  index + 24-bit data
//
//  One transaction is processed at a time; the next is taken while a
//  result waits in the output register.
//  Add, clear, unused codes, and queries of an empty table or an off-grid
//  cell go straight to the result state. Other queries pass every cell of
//  the chain, then the 17-step reciprocal divider.
//  Reset clears the light count and loads the register defaults; the
//  light table needs no clearing pass. A stalled output holds its result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module iso_grid_point_light_intensity_core import igpl_pkg::*; #(
    parameter int unsigned MAX_LIGHTS = MAX_LIGHTS_DEF,
    parameter int unsigned GRID_DIM   = GRID_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_LIGHTS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHAIN = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic signed [POS_W-1:0] r_org_x;
    logic signed [POS_W-1:0] r_org_y;
    logic [SCALE_W-1:0]      r_scale;
    t_out_item               r_res;
    t_out_item               n_res;
    t_out_item               r_out;
    t_out_item               n_out;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_tok                    r_tok_in;
    t_tok                    n_tok_in;
    t_tok                    w_tok [0:MAX_LIGHTS];

    logic                    w_in_acc;
    logic                    w_full;
    logic                    w_in_grid;
    logic                    w_add_wr;
    logic                    w_add_drop;
    logic signed [TC_W-1:0]  w_tx;
    logic signed [TC_W-1:0]  w_ty;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [Q_W-1:0]          w_quot;
    logic [INT_W-1:0]        w_int;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(MAX_LIGHTS));
    assign w_in_grid  = (32'(i_in.cell_col) < GRID_DIM) && (32'(i_in.cell_row) < GRID_DIM);
    assign w_add_wr   = w_in_acc && (i_in.req_type == REQ_ADD) && !w_full;
    assign w_add_drop = w_in_acc && (i_in.req_type == REQ_ADD) && w_full;

    // Isometric tile coordinates of the queried cell.
    assign w_tx = $signed({2'b0, i_in.cell_col}) + $signed({11'b0, i_in.cell_row[0]})
                + $signed({3'b0, i_in.cell_row[CELL_W-1:1]});
    assign w_ty = $signed({3'b0, i_in.cell_row[CELL_W-1:1]}) - $signed({2'b0, i_in.cell_col});

    // Configuration registers; the write port never back-pressures.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_scale <= SCALE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_org_x <= $signed(i_cfg_data[POS_W-1:0]);
                CFG_ORIGIN_Y:  r_org_y <= $signed(i_cfg_data[POS_W-1:0]);
                CFG_SCALE_INV: r_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Chain of light cells; the query token enters at cell zero.
    assign w_tok[0] = r_tok_in;

    for (genvar gi = 0; gi < MAX_LIGHTS; gi++) begin : g_cell
        igpl_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (w_add_wr && (r_count == CNT_W'(gi))),
            .i_light_x   (i_in.light_x),
            .i_light_y   (i_in.light_y),
            .i_used      (r_count > CNT_W'(gi)),
            .i_origin_x  (r_org_x),
            .i_origin_y  (r_org_y),
            .i_scale_inv (r_scale),
            .i_tok       (w_tok[gi]),
            .o_tok       (w_tok[gi+1])
        );
    end

    // Reciprocal of the smallest distance.
    igpl_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_best  (w_tok[MAX_LIGHTS].best),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_int = w_quot[Q_W-1] ? {INT_W{1'b1}} : w_quot[INT_W-1:0];

    // Transaction sequencer.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_tok_in     = r_tok_in;
        n_tok_in.vld = 1'b0;
        w_div_start  = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    unique case (i_in.req_type)
                        REQ_ADD: begin
                            if (w_full) begin
                                n_res.status = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            n_count = '0;
                        end
                        REQ_QUERY: begin
                            if ((r_count != '0) && w_in_grid) begin
                                n_tok_in.vld  = 1'b1;
                                n_tok_in.tx   = w_tx;
                                n_tok_in.ty   = w_ty;
                                n_tok_in.best = SQ_SAT;
                                n_state       = S_CHAIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CHAIN: begin
                if (w_tok[MAX_LIGHTS].vld) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res.intensity = w_int;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_tok_in.vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_tok_in    <= n_tok_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The token leaves the chain only while the sequencer waits for it.
    `ASSERT_IMPLIES(a_chain_exit, i_clk, i_rst_n, w_tok[MAX_LIGHTS].vld, r_state == S_CHAIN)
    // The divider finishes only while the sequencer waits for it.
    `ASSERT_IMPLIES(a_div_done, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    // A new result appears only after the result state.
    `ASSERT_IMPLIES(a_out_rise, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)
    // An add to a full table is flagged and leaves the count alone.
    `ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, w_add_drop, r_res.status && r_count == $past(r_count))

endmodule

// ===== hw/rtl/igpl_cell.sv =====
// ---------------------------------------------------------------------------
// Light cell
// Holds one light, keeps its scaled offset and folds its squared distance
// into the passing query token over three pipeline stages.
// ---------------------------------------------------------------------------
module igpl_cell import igpl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr,
    input  logic signed [POS_W-1:0] i_light_x,
    input  logic signed [POS_W-1:0] i_light_y,
    input  logic                    i_used,
    input  logic signed [POS_W-1:0] i_origin_x,
    input  logic signed [POS_W-1:0] i_origin_y,
    input  logic [SCALE_W-1:0]      i_scale_inv,
    input  t_tok                    i_tok,
    output t_tok                    o_tok
);

    localparam int unsigned OFS_W = POS_W + SCALE_W + 2;
    localparam int unsigned TQ_W  = TC_W + 16;
    localparam int unsigned D_W   = OFS_W + 2;
    localparam logic signed [D_W-1:0] HALF = 128;

    // Rounds |t*65536 - ofs| to Q.8; the top bit flags an out-of-range magnitude.
    function automatic logic [MAG_W:0] round_mag(input logic signed [TC_W-1:0] t,
                                                 input logic signed [OFS_W-1:0] ofs);
        logic signed [D_W-1:0] tq;
        logic signed [D_W-1:0] oo;
        logic signed [D_W-1:0] p;
        logic signed [D_W-1:0] n;
        logic [D_W-1:0]        sel;
        tq  = {{(D_W-TQ_W){t[TC_W-1]}}, t, 16'b0};
        oo  = {{(D_W-OFS_W){ofs[OFS_W-1]}}, ofs};
        p   = tq - oo + HALF;
        n   = oo - tq + HALF;
        sel = (n > HALF) ? n : p;
        return {|sel[D_W-1:MAG_W+8], sel[MAG_W+7:8]};
    endfunction

    logic signed [POS_W-1:0] r_lx;
    logic signed [POS_W-1:0] r_ly;
    logic signed [OFS_W-1:0] r_ox;
    logic signed [OFS_W-1:0] r_oy;
    logic signed [POS_W:0]   w_rx;
    logic signed [POS_W:0]   w_ry;
    logic signed [OFS_W-1:0] n_ox;
    logic signed [OFS_W-1:0] n_oy;

    t_tok             r_b_tok;
    logic [MAG_W:0]   r_b_mx;
    logic [MAG_W:0]   r_b_my;
    logic [MAG_W:0]   n_b_mx;
    logic [MAG_W:0]   n_b_my;
    t_tok             r_c_tok;
    logic [SQ_W-1:0]  r_c_sqx;
    logic [SQ_W-1:0]  r_c_sqy;
    logic             r_c_sat;
    t_tok             r_d_tok;
    logic [SQ_W:0]    w_sum;
    logic [SQ_W-1:0]  w_dist;
    t_tok             n_d_tok;

    // Light store, written by an add transaction.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_lx <= i_light_x;
            r_ly <= i_light_y;
        end
    end

    // Origin-shifted, scaled light offset in Q.16, refreshed every cycle.
    assign w_rx = $signed({r_lx[POS_W-1], r_lx}) - $signed({i_origin_x[POS_W-1], i_origin_x});
    assign w_ry = $signed({r_ly[POS_W-1], r_ly}) - $signed({i_origin_y[POS_W-1], i_origin_y});
    assign n_ox = w_rx * $signed({1'b0, i_scale_inv});
    assign n_oy = w_ry * $signed({1'b0, i_scale_inv});

    always_ff @(posedge i_clk) begin
        r_ox <= n_ox;
        r_oy <= n_oy;
    end

    // Stage B: per-axis rounded magnitudes.
    assign n_b_mx = round_mag(i_tok.tx, r_ox);
    assign n_b_my = round_mag(i_tok.ty, r_oy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tok.vld <= 1'b0;
        end else begin
            r_b_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mx <= n_b_mx;
        r_b_my <= n_b_my;
    end

    // Stage C: squares of the magnitudes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tok.vld <= 1'b0;
        end else begin
            r_c_tok <= r_b_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sqx <= r_b_mx[MAG_W-1:0] * r_b_mx[MAG_W-1:0];
        r_c_sqy <= r_b_my[MAG_W-1:0] * r_b_my[MAG_W-1:0];
        r_c_sat <= r_b_mx[MAG_W] | r_b_my[MAG_W];
    end

    // Stage D: saturating sum and running minimum.
    assign w_sum  = {1'b0, r_c_sqx} + {1'b0, r_c_sqy};
    assign w_dist = (r_c_sat || w_sum[SQ_W]) ? SQ_SAT : w_sum[SQ_W-1:0];

    always_comb begin
        n_d_tok = r_c_tok;
        if (i_used && (w_dist < r_c_tok.best)) begin
            n_d_tok.best = w_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_tok.vld <= 1'b0;
        end else begin
            r_d_tok <= n_d_tok;
        end
    end

    assign o_tok = r_d_tok;

endmodule

// ===== hw/rtl/igpl_recip.sv =====
// ---------------------------------------------------------------------------
// Intensity reciprocal
// Restoring divider, one quotient bit per cycle, giving the rounded value
// of 100*2^32 / (6553600 + S).
// ---------------------------------------------------------------------------
module igpl_recip import igpl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQ_W-1:0] i_best,
    output logic            o_done,
    output logic [Q_W-1:0]  o_quot
);

    localparam int unsigned CNT_W = $clog2(Q_W);

    logic [DEN_W-1:0] r_den;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_dsh;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_load;
    logic             r_run;
    logic             r_done;
    logic             w_ge;
    logic [REM_W-1:0] w_diff;

    assign w_ge   = (r_rem >= r_dsh);
    assign w_diff = r_rem - r_dsh;

    // Sequencing: latch divisor, load remainder, then one step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_load <= 1'b1;
            end else if (r_load) begin
                r_load <= 1'b0;
                r_run  <= 1'b1;
                r_cnt  <= CNT_W'(Q_W - 1);
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: the rounding half of the divisor is folded into the dividend.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= {1'b0, i_best} + DEN_OFS;
        end
        if (r_load) begin
            r_rem <= DIV_NUM + REM_W'(r_den >> 1);
            r_dsh <= REM_W'({r_den, {(Q_W-1){1'b0}}});
            r_q   <= '0;
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= w_diff;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Isometric grid point-light intensity core testbench
// Drives add, clear and query transactions with random burst gaps and
// output stalls, predicts every result with an in-bench light table
// model and compares each result field by field in arrival order.
// ---------------------------------------------------------------------------
module testbench;
    import igpl_pkg::*;

    localparam int unsigned TABLE_DEPTH    = MAX_LIGHTS_DEF;
    localparam int unsigned GRID_CELLS     = GRID_DIM_DEF;
    localparam logic [1:0]  REQ_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int          DRAIN_CYCLES   = 3 * TABLE_DEPTH + 40;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_ITEMS   = 1150;
    localparam longint unsigned RECIP_NUM  = 64'd429496729600;
    localparam longint unsigned RECIP_OFS  = 64'd6553600;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} t_stall_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    // Model of the light table and the view registers.
    logic signed [POS_W-1:0] table_x [TABLE_DEPTH];
    logic signed [POS_W-1:0] table_y [TABLE_DEPTH];
    int unsigned             table_count = 0;
    logic signed [POS_W-1:0] view_org_x  = '0;
    logic signed [POS_W-1:0] view_org_y  = '0;
    logic [SCALE_W-1:0]      view_scale  = SCALE_RST;

    t_out_item pending_results [$];
    t_out_item oldest_result;
    int        error_count  = 0;
    int        sent_items   = 0;
    int        burst_left   = 0;
    int        quiet_cycles = 0;
    bit        hold_request = 1'b0;

    iso_grid_point_light_intensity_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Squared magnitude of one Q.16 axis difference, rounded to Q.8 first.
    function automatic longint unsigned axis_square(input longint d);
        longint unsigned mag;
        longint unsigned mag8;
        mag  = (d < 0) ? -d : d;
        mag8 = (mag + 128) >> 8;
        if (mag8 >= (64'd1 << MAG_W)) return SQ_SAT;
        return mag8 * mag8;
    endfunction

    // Intensity of one cell from the closest stored light.
    function automatic logic [INT_W-1:0] cell_intensity(input logic [CELL_W-1:0] col,
                                                        input logic [CELL_W-1:0] row);
        longint          tx, ty, ox, oy;
        longint unsigned best, sq_dist, den, q;
        if (table_count == 0 || col >= GRID_CELLS || row >= GRID_CELLS) return '0;
        tx   = longint'(col) + longint'(row[0]) + longint'(row >> 1);
        ty   = longint'(row >> 1) - longint'(col);
        best = SQ_SAT;
        for (int k = 0; k < table_count; k++) begin
            ox      = (longint'(table_x[k]) - longint'(view_org_x)) * longint'(view_scale);
            oy      = (longint'(table_y[k]) - longint'(view_org_y)) * longint'(view_scale);
            sq_dist = axis_square(tx * 65536 - ox) + axis_square(ty * 65536 - oy);
            if (sq_dist > SQ_SAT) sq_dist = SQ_SAT;
            if (sq_dist < best) best = sq_dist;
        end
        den = RECIP_OFS + best;
        q   = (RECIP_NUM + den / 2) / den;
        return (q > 65535) ? 16'hFFFF : q[INT_W-1:0];
    endfunction

    // Applies one request to the table model and returns its result.
    function automatic t_out_item light_table_step(input t_in_item it);
        t_out_item res;
        res = '0;
        case (it.req_type)
            REQ_ADD: begin
                if (table_count < TABLE_DEPTH) begin
                    table_x[table_count] = it.light_x;
                    table_y[table_count] = it.light_y;
                    table_count++;
                end else begin
                    res.status = 1'b1;
                end
            end
            REQ_CLEAR: table_count = 0;
            REQ_QUERY: res.intensity = cell_intensity(it.cell_col, it.cell_row);
            default: ;
        endcase
        return res;
    endfunction

    // Light position that lands close to the tile of the given cell.
    function automatic void light_near_cell(input logic [CELL_W-1:0] col,
                                            input logic [CELL_W-1:0] row,
                                            output logic signed [POS_W-1:0] lx,
                                            output logic signed [POS_W-1:0] ly);
        longint tx, ty, ex, ey, px, py;
        int     span;
        tx   = longint'(col) + longint'(row[0]) + longint'(row >> 1);
        ty   = longint'(row >> 1) - longint'(col);
        span = $urandom_range(6, 21);
        ex   = longint'($urandom_range(0, (1 << span) - 1));
        ey   = longint'($urandom_range(0, (1 << span) - 1));
        if ($urandom_range(0, 1)) ex = -ex;
        if ($urandom_range(0, 1)) ey = -ey;
        if (view_scale == 0) begin
            px = longint'($urandom);
            py = longint'($urandom);
        end else begin
            px = (tx * 65536 + ex) / longint'(view_scale);
            py = (ty * 65536 + ey) / longint'(view_scale);
        end
        lx = POS_W'(px + longint'(view_org_x));
        ly = POS_W'(py + longint'(view_org_y));
    endfunction

    // Offers one request transaction, inserting a random gap between bursts.
    task automatic send_item(input logic [1:0] req, input logic signed [POS_W-1:0] lx,
                             input logic signed [POS_W-1:0] ly,
                             input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row);
        int       gap;
        t_in_item it;
        it = '{req_type: req, light_x: lx, light_y: ly, cell_col: col, cell_row: row};
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(light_table_step(it));
        sent_items++;
    endtask

    task automatic send_noise();
        send_item(2'($urandom), POS_W'($urandom), POS_W'($urandom),
                  CELL_W'($urandom), CELL_W'($urandom));
    endtask

    // Waits until every expected result has come and the block has settled.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ORIGIN_X:  view_org_x = data;
            CFG_ORIGIN_Y:  view_org_y = data;
            CFG_SCALE_INV: view_scale = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrites all view registers while the block is idle.
    task automatic write_view(input logic signed [POS_W-1:0] ox,
                              input logic signed [POS_W-1:0] oy,
                              input logic [SCALE_W-1:0] sc, input bit poke_unused);
        wait_idle();
        cfg_beat(CFG_ORIGIN_X, ox);
        cfg_beat(CFG_ORIGIN_Y, oy);
        cfg_beat(CFG_SCALE_INV, {8'($urandom), sc});
        if (poke_unused) cfg_beat(CFG_UNUSED, CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // One scene: clear, place lights near chosen cells, then query around them.
    task automatic run_scene();
        logic [CELL_W-1:0]       anchor_col [20];
        logic [CELL_W-1:0]       anchor_row [20];
        logic signed [POS_W-1:0] lx, ly;
        logic [CELL_W-1:0]       col, row;
        int                      n_lights, n_queries, pick, roll;
        send_item(REQ_CLEAR, POS_W'($urandom), POS_W'($urandom),
                  CELL_W'($urandom), CELL_W'($urandom));
        roll = $urandom_range(0, 9);
        if (roll < 7)      n_lights = $urandom_range(1, 6);
        else if (roll < 9) n_lights = $urandom_range(7, TABLE_DEPTH);
        else               n_lights = $urandom_range(TABLE_DEPTH + 1, 20);
        for (int i = 0; i < n_lights; i++) begin
            anchor_col[i] = CELL_W'($urandom);
            anchor_row[i] = CELL_W'($urandom);
            light_near_cell(anchor_col[i], anchor_row[i], lx, ly);
            send_item(REQ_ADD, lx, ly, CELL_W'($urandom), CELL_W'($urandom));
        end
        n_queries = $urandom_range(6, 20);
        for (int i = 0; i < n_queries; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                send_noise();
            end else begin
                if (roll < 85) begin
                    pick = $urandom_range(0, n_lights - 1);
                    col  = anchor_col[pick] + CELL_W'($urandom_range(0, 6)) - CELL_W'(3);
                    row  = anchor_row[pick] + CELL_W'($urandom_range(0, 6)) - CELL_W'(3);
                end else begin
                    col = CELL_W'($urandom);
                    row = CELL_W'($urandom);
                end
                send_item(REQ_QUERY, POS_W'($urandom), POS_W'($urandom), col, row);
            end
        end
    endtask

    // Edge values of every field, each request code and the empty table.
    task automatic test_directed_edges();
        logic signed [POS_W-1:0] lx, ly;
        send_item(REQ_QUERY, '0, '0, '0, '0);
        send_item(REQ_ADD, '0, '0, '1, '1);
        send_item(REQ_QUERY, '1, '1, '0, '0);
        send_item(REQ_QUERY, '0, '0, '1, '1);
        send_item(REQ_ADD, 24'sh800000, 24'sh800000, '0, '0);
        send_item(REQ_ADD, 24'sh7FFFFF, 24'sh7FFFFF, '0, '0);
        send_item(REQ_QUERY, '0, '0, '1, '0);
        send_item(REQ_QUERY, '0, '0, '0, '1);
        send_item(REQ_UNUSED, POS_W'($urandom), POS_W'($urandom), '1, '1);
        send_item(REQ_QUERY, '0, '0, 10'd512, 10'd511);
        send_item(REQ_CLEAR, '1, '1, '1, '1);
        send_item(REQ_QUERY, '0, '0, '0, '0);
        light_near_cell(10'd5, 10'd7, lx, ly);
        send_item(REQ_ADD, lx, ly, '0, '0);
        send_item(REQ_QUERY, '0, '0, 10'd5, 10'd7);
        send_item(REQ_QUERY, '0, '0, 10'd6, 10'd7);
    endtask

    // Fills the table past its depth so that further adds are dropped.
    task automatic test_table_full();
        logic signed [POS_W-1:0] lx, ly;
        logic [CELL_W-1:0]       col, row;
        col = CELL_W'($urandom);
        row = CELL_W'($urandom);
        send_item(REQ_CLEAR, '0, '0, '0, '0);
        for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
            light_near_cell(col, row, lx, ly);
            send_item(REQ_ADD, lx, ly, CELL_W'($urandom), CELL_W'($urandom));
        end
        send_item(REQ_QUERY, '0, '0, col, row);
        send_item(REQ_ADD, '1, '1, '0, '0);
        send_item(REQ_CLEAR, '0, '0, '0, '0);
        light_near_cell(col, row, lx, ly);
        send_item(REQ_ADD, lx, ly, '0, '0);
        send_item(REQ_QUERY, '0, '0, col, row);
    endtask

    // Extreme view settings, with a scene run under each.
    task automatic test_view_extremes();
        write_view(24'sh800000, 24'sh7FFFFF, 16'd0, 1'b0);
        run_scene();
        write_view(24'sh7FFFFF, 24'sh800000, 16'hFFFF, 1'b1);
        run_scene();
        write_view('0, '0, 16'd1, 1'b1);
        run_scene();
        write_view(POS_W'($urandom), POS_W'($urandom), SCALE_RST, 1'b0);
        run_scene();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        wait_idle();
        hold_request = 1'b1;
        burst_left   = 60;
        run_scene();
    endtask

    // Random scenes, with the view registers changed now and then.
    task automatic test_random_scenes();
        int stop_at;
        logic [SCALE_W-1:0] sc;
        stop_at = sent_items + RANDOM_ITEMS;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0:       sc = SCALE_RST;
                    1:       sc = SCALE_W'($urandom);
                    2:       sc = ($urandom_range(0, 1)) ? 16'd0 : 16'hFFFF;
                    default: sc = SCALE_W'($urandom_range(1, 1024));
                endcase
                write_view(POS_W'($urandom), POS_W'($urandom), sc, $urandom_range(0, 1));
            end
            run_scene();
        end
    endtask

    // Receiver stall pattern, with a long hold-off when one is requested.
    initial begin : stall_gen
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:     i_out_stall <= 1'b0;
                    STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 99) < 40);
                    STALL_PERIODIC: i_out_stall <= (mode_left % 4 == 0);
                    default:        i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result: intensity %0d status %0d",
                             o_out.intensity, o_out.status);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (oldest_result.intensity != o_out.intensity ||
                    oldest_result.status != o_out.status) begin
                    if (error_count < 10)
                        $display("mismatch: expected intensity %0d status %0d, got %0d %0d",
                                 oldest_result.intensity, oldest_result.status,
                                 o_out.intensity, o_out.status);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when no transaction has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_table_full();
        test_view_extremes();
        test_output_backpressure();
        test_random_scenes();
        wait_idle();
        if (error_count == 0 && pending_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== iso_grid_point_light_intensity_core.f =====
+incdir+hw/rtl
hw/rtl/igpl_pkg.sv
hw/rtl/igpl_cell.sv
hw/rtl/igpl_recip.sv
hw/rtl/iso_grid_point_light_intensity_core.sv
dv/testbench.sv
